>>> sv/trpm_pkg.sv
// shared constants and types for the torque request plausibility monitor
package trpm_pkg;

  localparam int unsigned TQ_W    = 16;
  localparam int unsigned STATE_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SUM_W   = TQ_W + 2;

  // request state that brings the drag torque in
  localparam logic [STATE_W-1:0] DRAG_STATE = 8'd6;

  localparam logic [TQ_W-1:0] COUNT_STEP = 16'd4;
  localparam logic [TQ_W-1:0] DELAY_CAP  = 16'd65500;

  localparam logic signed [TQ_W-1:0] TQ_MAX = 16'sd32000;
  localparam logic signed [TQ_W-1:0] TQ_MIN = -16'sd32000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERROR_MARGIN    = 2'd0,
    REG_FAULT_ON_DELAY  = 2'd1,
    REG_FAULT_OFF_DELAY = 2'd2
  } cfg_reg_t;

  typedef logic signed [TQ_W-1:0] torque_t;

endpackage

>>> sv/trpm_if.sv
// valid/ready channels for input ticks and result beats
interface trpm_tick_if;
  logic                            valid;
  logic                            ready;
  logic [trpm_pkg::STATE_W-1:0]    request_state;
  logic signed [trpm_pkg::TQ_W-1:0] driver_torque;
  logic signed [trpm_pkg::TQ_W-1:0] chassis_request;
  logic signed [trpm_pkg::TQ_W-1:0] drag_torque;

  modport source (output valid, request_state, driver_torque, chassis_request, drag_torque,
                  input ready);
  modport sink   (input valid, request_state, driver_torque, chassis_request, drag_torque,
                  output ready);
endinterface

interface trpm_status_if;
  logic                             valid;
  logic                             ready;
  logic signed [trpm_pkg::TQ_W-1:0] permitted_limit;
  logic signed [trpm_pkg::TQ_W-1:0] clamped_request;
  logic                             fault;

  modport source (output valid, permitted_limit, clamped_request, fault, input ready);
  modport sink   (input valid, permitted_limit, clamped_request, fault, output ready);
endinterface

>>> sv/torque_request_plausibility_monitor.sv
// torque request plausibility monitor: limit check, asymmetric debounce, fault latch
//
// usage
//   tick   : one beat per control tick (request state, driver, chassis request, drag torque)
//   status : one beat per tick (permitted limit, clamped request, latched fault)
//   cfg    : plain write port, error margin / on-delay / off-delay, written while idle
// timing
//   a tick beat lands in the input register at the accepting edge; the limit check and
//   debounce then run combinationally and load the status register as soon as it is free,
//   which offers the result beat; one beat per cycle sustained while the receiver keeps
//   ready high, with the compare/add path lying between the input and status registers
// stall
//   the status register holds its beat while the receiver stalls; the input register
//   still takes one more tick, then ready drops until the status beat is taken
// reset
//   rst (synchronous) clears both valid flags, the debounce state and the fault latch,
//   and sets all configuration registers to 0
module torque_request_plausibility_monitor (
  input  logic                               clk,
  input  logic                               rst,
  trpm_tick_if.sink                          tick,
  trpm_status_if.source                      status,
  input  logic                               cfg_write,
  input  logic [trpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trpm_pkg::TQ_W-1:0]          cfg_data
);

  // configuration registers
  logic [trpm_pkg::TQ_W-1:0] error_margin;
  logic [trpm_pkg::TQ_W-1:0] fault_on_delay;
  logic [trpm_pkg::TQ_W-1:0] fault_off_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_margin    <= '0;
      fault_on_delay  <= '0;
      fault_off_delay <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        trpm_pkg::REG_ERROR_MARGIN:    error_margin    <= cfg_data;
        trpm_pkg::REG_FAULT_ON_DELAY:  fault_on_delay  <= cfg_data;
        trpm_pkg::REG_FAULT_OFF_DELAY: fault_off_delay <= cfg_data;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // input register stage
  logic                             in_valid;
  logic [trpm_pkg::STATE_W-1:0]     in_state;
  trpm_pkg::torque_t                in_driver;
  trpm_pkg::torque_t                in_request;
  trpm_pkg::torque_t                in_drag;

  logic tick_fire;
  logic step_fire;   // input stage item moves into the status register

  assign step_fire  = in_valid && (!status.valid || status.ready);
  assign tick.ready = !in_valid || step_fire;
  assign tick_fire  = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick_fire) begin
      in_valid <= 1'b1;
    end else if (step_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      in_state   <= tick.request_state;
      in_driver  <= tick.driver_torque;
      in_request <= tick.chassis_request;
      in_drag    <= tick.drag_torque;
    end
  end

  // permitted limit: base torque plus margin at full width, then saturate
  trpm_pkg::torque_t                 base_tq;
  logic signed [trpm_pkg::SUM_W-1:0] limit_sum;
  trpm_pkg::torque_t                 limit_sat;
  trpm_pkg::torque_t                 request_sat;
  logic                              exceeded;

  always_comb begin
    if (in_state == trpm_pkg::DRAG_STATE && in_drag > in_driver) begin
      base_tq = in_drag;
    end else begin
      base_tq = in_driver;
    end
    limit_sum = {{2{base_tq[trpm_pkg::TQ_W-1]}}, base_tq} + {2'b00, error_margin};
    priority if (limit_sum > trpm_pkg::SUM_W'(trpm_pkg::TQ_MAX)) begin
      limit_sat = trpm_pkg::TQ_MAX;
    end else if (limit_sum < trpm_pkg::SUM_W'(trpm_pkg::TQ_MIN)) begin
      limit_sat = trpm_pkg::TQ_MIN;
    end else begin
      limit_sat = limit_sum[trpm_pkg::TQ_W-1:0];
    end
    priority if (in_request > trpm_pkg::TQ_MAX) begin
      request_sat = trpm_pkg::TQ_MAX;
    end else if (in_request < trpm_pkg::TQ_MIN) begin
      request_sat = trpm_pkg::TQ_MIN;
    end else begin
      request_sat = in_request;
    end
    // compare against the raw request, not the clamped one
    exceeded = limit_sat < in_request;
  end

  // debounce state
  logic                      exceeded_before;
  logic [trpm_pkg::TQ_W-1:0] delay_count;
  logic                      fault_latch;
  logic [trpm_pkg::TQ_W-1:0] delay_count_next;
  logic [trpm_pkg::TQ_W-1:0] delay_load;
  logic                      fault_latch_next;
  logic                      set_in;
  logic                      rst_in;

  always_comb begin
    delay_load = exceeded ? fault_on_delay : fault_off_delay;
    if (delay_load > trpm_pkg::DELAY_CAP) begin
      delay_load = trpm_pkg::DELAY_CAP;
    end
    if (exceeded != exceeded_before) begin
      // sense changed: reload, no count this tick
      delay_count_next = delay_load;
    end else if (delay_count > trpm_pkg::COUNT_STEP) begin
      delay_count_next = delay_count - trpm_pkg::COUNT_STEP;
    end else begin
      delay_count_next = '0;
    end
    set_in           = exceeded && (delay_count_next == '0);
    rst_in           = !exceeded && (delay_count_next == '0);
    // reset dominant latch
    fault_latch_next = !rst_in && (set_in || fault_latch);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exceeded_before <= 1'b0;
      delay_count     <= '0;
      fault_latch     <= 1'b0;
    end else if (step_fire) begin
      exceeded_before <= exceeded;
      delay_count     <= delay_count_next;
      fault_latch     <= fault_latch_next;
    end
  end

  // status register
  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (step_fire) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      status.permitted_limit <= limit_sat;
      status.clamped_request <= request_sat;
      status.fault           <= fault_latch_next;
    end
  end

  // checks
  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    delay_count <= trpm_pkg::DELAY_CAP)
    else $error("delay count above cap");

  a_latch_quiet: assert property (@(posedge clk) disable iff (rst)
    !step_fire |=> $stable(fault_latch) && $stable(delay_count))
    else $error("debounce state moved without a tick");

  a_fault_beat: assert property (@(posedge clk) disable iff (rst)
    step_fire |=> status.valid && status.fault == fault_latch)
    else $error("status beat fault differs from latch");

  a_set_needs_exceed: assert property (@(posedge clk) disable iff (rst)
    $rose(fault_latch) |-> exceeded_before)
    else $error("fault set while not exceeded");

  a_clear_needs_ok: assert property (@(posedge clk) disable iff (rst)
    $fell(fault_latch) |-> !exceeded_before)
    else $error("fault cleared while exceeded");

endmodule

>>> verif/tb_top.sv
// testbench for the torque request plausibility monitor: limit check, debounce and fault latch
`timescale 1ns / 100ps

module tb_top;

  // the design offers a result from its status register, behind its input register
  localparam int DUT_LATENCY = 2;
  // generous bound: about 550 ticks that may each wait out the longest sender gap and
  // the longest receiver stall, plus register writes and drains
  localparam int CYCLE_LIMIT = 200_000;
  // ticks of one comparison sense while the delays sit at or above the cap
  localparam int CAP_RUN = 12;
  // register index beyond the three real registers; writes to it must be ignored
  localparam logic [trpm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [trpm_pkg::STATE_W-1:0] state;
    trpm_pkg::torque_t            driver;
    trpm_pkg::torque_t            request;
    trpm_pkg::torque_t            drag;
  } tick_t;

  typedef struct {
    trpm_pkg::torque_t limit;
    trpm_pkg::torque_t clamped;
    logic              fault;
  } status_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [trpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [trpm_pkg::TQ_W-1:0]      cfg_data = '0;

  trpm_tick_if   tick_bus ();
  trpm_status_if status_bus ();

  torque_request_plausibility_monitor u_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_bus),
    .status    (status_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the configuration registers, kept in step with each write
  logic [trpm_pkg::TQ_W-1:0] margin_q   = '0;
  logic [trpm_pkg::TQ_W-1:0] on_delay_q = '0;
  logic [trpm_pkg::TQ_W-1:0] off_delay_q = '0;

  // shadow of the debounce state
  logic                      exceeded_q = 1'b0;
  logic [trpm_pkg::TQ_W-1:0] count_q    = '0;
  logic                      fault_q    = 1'b0;

  tick_t   pending_ticks[$];   // ticks waiting to be offered
  status_t due_status[$];      // predicted status beats, oldest first
  tick_t   in_flight;          // tick currently on the bus

  bit no_idle = 1'b0;          // both sides run flat out while set
  int mismatches = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int fault_rises = 0;
  int reg_writes = 0;
  int cycles = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int sat_torque(int v);
    if (v < int'(trpm_pkg::TQ_MIN)) return int'(trpm_pkg::TQ_MIN);
    if (v > int'(trpm_pkg::TQ_MAX)) return int'(trpm_pkg::TQ_MAX);
    return v;
  endfunction

  // driver torque, or the larger of driver and drag torque in the drag state,
  // plus the margin; the sum is formed in 32 bits so nothing wraps before saturation
  function automatic int permitted_of(tick_t t);
    int base;
    base = int'(t.driver);
    if (t.state == trpm_pkg::DRAG_STATE && t.drag > t.driver) base = int'(t.drag);
    return sat_torque(base + int'(margin_q));
  endfunction

  // one control tick: limit check, asymmetric debounce, reset-dominant latch
  function automatic status_t plausibility_step(tick_t t);
    status_t s;
    int      limit;
    logic    over;
    logic    set_in;
    logic    clr_in;
    limit  = permitted_of(t);
    over   = int'(t.request) > limit;
    set_in = 1'b0;
    clr_in = 1'b0;
    if (over != exceeded_q) begin
      // change of sense loads the matching delay and skips the decrement
      if (over) begin
        count_q = (on_delay_q > trpm_pkg::DELAY_CAP) ? trpm_pkg::DELAY_CAP : on_delay_q;
      end else begin
        count_q = (off_delay_q > trpm_pkg::DELAY_CAP) ? trpm_pkg::DELAY_CAP : off_delay_q;
      end
    end else if (count_q > 0) begin
      count_q = (count_q > trpm_pkg::COUNT_STEP) ? count_q - trpm_pkg::COUNT_STEP : '0;
    end
    // a zero delay lets set or reset act on the very tick of the change
    if (over) set_in = (count_q == 0);
    else      clr_in = (count_q == 0);
    exceeded_q = over;
    fault_q    = !clr_in && (set_in || fault_q);
    s.limit   = trpm_pkg::torque_t'(limit);
    s.clamped = trpm_pkg::torque_t'(sat_torque(int'(t.request)));
    s.fault   = fault_q;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic trpm_pkg::torque_t rand_torque();
    case ($urandom_range(0, 7))
      0:       return trpm_pkg::torque_t'(-32768);
      1:       return trpm_pkg::torque_t'(32767);
      2:       return trpm_pkg::TQ_MIN;
      3:       return trpm_pkg::TQ_MAX;
      default: return trpm_pkg::torque_t'($urandom);
    endcase
  endfunction

  function automatic logic [trpm_pkg::STATE_W-1:0] rand_state();
    case ($urandom_range(0, 3))
      0, 1:    return trpm_pkg::DRAG_STATE;
      2:       return ($urandom_range(0, 1) != 0) ? trpm_pkg::DRAG_STATE + 8'd1
                                                  : trpm_pkg::DRAG_STATE - 8'd1;
      default: return trpm_pkg::STATE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // random tick whose chassis request lands on the chosen side of its limit,
  // often right at the boundary
  function automatic tick_t make_tick(bit over);
    tick_t t;
    int    limit;
    t.state  = rand_state();
    t.driver = rand_torque();
    t.drag   = rand_torque();
    limit    = permitted_of(t);
    if (over) begin
      case ($urandom_range(0, 3))
        0:       t.request = trpm_pkg::torque_t'(limit + 1);
        1:       t.request = trpm_pkg::torque_t'(32767);
        default: t.request = trpm_pkg::torque_t'(limit + 1 +
                                                 int'($urandom_range(0, 32766 - limit)));
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0:       t.request = trpm_pkg::torque_t'(limit);
        1:       t.request = trpm_pkg::torque_t'(-32768);
        default: t.request = trpm_pkg::torque_t'(-32768 +
                                                 int'($urandom_range(0, limit + 32768)));
      endcase
    end
    return t;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.state   = trpm_pkg::STATE_W'($urandom_range(0, 255));
    t.driver  = trpm_pkg::torque_t'($urandom);
    t.request = trpm_pkg::torque_t'($urandom);
    t.drag    = trpm_pkg::torque_t'($urandom);
    return t;
  endfunction

  task automatic push_tick(logic [trpm_pkg::STATE_W-1:0] st, int drv, int req, int drg);
    tick_t t;
    t.state   = st;
    t.driver  = trpm_pkg::torque_t'(drv);
    t.request = trpm_pkg::torque_t'(req);
    t.drag    = trpm_pkg::torque_t'(drg);
    pending_ticks.push_back(t);
  endtask

  // runs of one comparison sense, sized around the current delays so the latch
  // both sets and clears, with some unshaped ticks mixed in
  task automatic queue_debounce_runs(int count);
    int       span;
    int       run;
    bit       over;
    logic [trpm_pkg::TQ_W-1:0] longest;
    longest = (on_delay_q > off_delay_q) ? on_delay_q : off_delay_q;
    span    = int'(longest) / 4 + 3;
    over    = ($urandom_range(0, 1) != 0);
    while (count > 0) begin
      run = $urandom_range(1, span);
      for (int i = 0; i < run && count > 0; i++) begin
        if ($urandom_range(0, 9) == 0) pending_ticks.push_back(noise_tick());
        else                          pending_ticks.push_back(make_tick(over));
        count--;
      end
      over = !over;
    end
  endtask

  // register write on the plain port; the shadow follows at the same edge
  task automatic write_reg(logic [trpm_pkg::CFG_IDX_W-1:0] idx,
                           logic [trpm_pkg::TQ_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      trpm_pkg::REG_ERROR_MARGIN:    margin_q    = val;
      trpm_pkg::REG_FAULT_ON_DELAY:  on_delay_q  = val;
      trpm_pkg::REG_FAULT_OFF_DELAY: off_delay_q = val;
      default: ;  // spare index, the design drops it
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic write_all(logic [trpm_pkg::TQ_W-1:0] margin, logic [trpm_pkg::TQ_W-1:0] on_d,
                           logic [trpm_pkg::TQ_W-1:0] off_d);
    write_reg(trpm_pkg::REG_ERROR_MARGIN, margin);
    write_reg(trpm_pkg::REG_FAULT_ON_DELAY, on_d);
    write_reg(trpm_pkg::REG_FAULT_OFF_DELAY, off_d);
  endtask

  // the sequence waits until every tick is out and every status beat is back;
  // checked at the falling edge, away from the driver and monitor updates
  task automatic settle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || tick_bus.valid || due_status.size() != 0);
    repeat (DUT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("mismatch %0d at status beat %0d: %s got %0d want %0d",
             mismatches, results_checked, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued ticks, predicts each one as it is accepted
  // ---------------------------------------------------------------------------

  int send_gap = 0;

  always @(posedge clk) begin : tick_driver
    tick_t nxt;
    if (rst) begin
      tick_bus.valid           <= 1'b0;
      tick_bus.request_state   <= '0;
      tick_bus.driver_torque   <= '0;
      tick_bus.chassis_request <= '0;
      tick_bus.drag_torque     <= '0;
      send_gap = 0;
    end else begin
      // beat taken at this edge: predict it while the shadow state is current
      if (tick_bus.valid && tick_bus.ready) begin
        due_status.push_back(plausibility_step(in_flight));
        ticks_sent++;
      end
      if (!tick_bus.valid || tick_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          tick_bus.valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          nxt = pending_ticks.pop_front();
          in_flight                <= nxt;
          tick_bus.request_state   <= nxt.state;
          tick_bus.driver_torque   <= nxt.driver;
          tick_bus.chassis_request <= nxt.request;
          tick_bus.drag_torque     <= nxt.drag;
          tick_bus.valid           <= 1'b1;
          send_gap = idle_len();
        end else begin
          tick_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls at random, checks every status beat against the oldest prediction
  // ---------------------------------------------------------------------------

  int   stall_left = 0;
  logic last_fault = 1'b0;

  always @(posedge clk) begin : status_monitor
    status_t want;
    if (rst) begin
      status_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (status_bus.valid && status_bus.ready) begin
        if (due_status.size() == 0) begin
          report_mismatch("beat with nothing due, limit", int'(status_bus.permitted_limit), 0);
        end else begin
          want = due_status.pop_front();
          if (status_bus.permitted_limit !== want.limit)
            report_mismatch("permitted_limit", int'(status_bus.permitted_limit),
                            int'(want.limit));
          if (status_bus.clamped_request !== want.clamped)
            report_mismatch("clamped_request", int'(status_bus.clamped_request),
                            int'(want.clamped));
          if (status_bus.fault !== want.fault)
            report_mismatch("fault", int'(status_bus.fault), int'(want.fault));
          if (want.fault && !last_fault) fault_rises++;
          last_fault = want.fault;
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        status_bus.ready <= 1'b0;
      end else begin
        status_bus.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status beats still due", cycles,
               due_status.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // all registers at reset: zero margin, zero delays, so the latch follows at once
    push_tick(8'd0, 0, 0, 0);                  // request equal to limit is not exceeded
    push_tick(8'd0, 0, 1, 0);                  // one above: sets on the same tick
    push_tick(8'd0, 0, 0, 0);                  // back at the limit: clears on the same tick
    push_tick(8'd0, -32768, -32768, 0);        // limit and request both saturate low
    push_tick(8'd0, 32767, 32767, 0);          // both saturate high, request still above
    push_tick(trpm_pkg::DRAG_STATE, -100, 400, 500);   // drag torque wins, request under it
    push_tick(trpm_pkg::DRAG_STATE, -100, -50, -500);  // drag lower, driver torque stays
    push_tick(trpm_pkg::DRAG_STATE + 8'd1, -100, 400, 500); // drag ignored outside its state
    push_tick(8'd255, 32767, -32768, -32768);
    push_tick(trpm_pkg::DRAG_STATE, -32768, 32000, 32767);
    settle();

    // largest margin: driver torque at its floor still saturates the sum high
    write_reg(trpm_pkg::REG_ERROR_MARGIN, 16'hFFFF);
    push_tick(8'd0, -32768, 32001, 0);
    push_tick(8'd0, -32768, 32000, 0);
    push_tick(trpm_pkg::DRAG_STATE, 0, 32767, 32767);
    settle();

    // short delays: the latch needs several ticks of one sense to move
    write_all(16'd100, 16'd8, 16'd12);
    for (int i = 0; i < 4; i++) push_tick(8'd0, 1000, 1200, 0);
    for (int i = 0; i < 5; i++) push_tick(8'd0, 1000, 1100, 0);
    push_tick(8'd0, 1000, 1101, 0);            // brief excursion restarts the on-delay
    settle();

    // delays at and above the cap: the capped count loads on each change of sense and
    // the short second run stays well inside it, so the latch holds through that run
    no_idle = 1'b1;
    write_all(16'd0, 16'hFFFF, trpm_pkg::DELAY_CAP);
    for (int i = 0; i < CAP_RUN; i++) pending_ticks.push_back(make_tick(1'b1));
    for (int i = 0; i < CAP_RUN; i++) pending_ticks.push_back(make_tick(1'b0));
    settle();
    no_idle = 1'b0;

    // random debounce traffic under several register settings; each phase is sent
    // in two halves with a full drain between them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 40)));
        1: write_all(16'd0, 16'd0, 16'd0);
        2: begin
          write_all(16'hFFFF, 16'd4, 16'd5);
          write_reg(REG_SPARE, 16'($urandom));
        end
        3: write_all(16'($urandom), 16'd1, 16'd3);
        4: write_all(16'($urandom_range(0, 300)), 16'd40, 16'd0);
        default: write_all(16'($urandom), 16'($urandom_range(0, 60)),
                           16'($urandom_range(0, 60)));
      endcase
      // one phase runs without any idling on either side
      no_idle = (phase == 3);
      queue_debounce_runs(40);
      settle();
      queue_debounce_runs(40);
      settle();
    end
    no_idle = 1'b0;

    $display("covered %0d ticks and %0d status beats, %0d fault sets, %0d register writes",
             ticks_sent, results_checked, fault_rises, reg_writes);
    $display("settings ranged from zero margin and delays to full scale and capped delays");
    if (mismatches == 0 && due_status.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
